@@ src/assert_macros.svh @@
// Assertion macros for the checker file mqrb_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mqrb_pkg.sv @@
`default_nettype none

package mqrb_pkg;

    localparam int WORD_BITS   = 64;
    localparam int QSEL_BITS   = 2;
    localparam int STATUS_BITS = 2;

    localparam int NUM_QUEUES_DEF = 3;
    localparam int RING_DEPTH_DEF = 16;
    localparam int ITEM_BITS_DEF  = 64;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

endpackage

`default_nettype wire

@@ src/multi_queue_ring_buffer_unit.sv @@
`default_nettype none

// Up to four independent circular FIFOs sharing one slot memory. Each request
// either enqueues item_word to the selected queue or dequeues from it, and
// gives exactly one result with a status (done, full, empty, invalid queue)
// and the empty/full state of that queue after the request. One request is
// accepted per clock while in_stall is low; its status and flags are registered
// in the s1 stage on acceptance and move on to the output register when it is
// free, and the output register lets the next request enter while a result waits.
// Head and tail pointers live in flip-flops; slots live in one synchronous
// single-port memory of NUM_QUEUES*RING_DEPTH words, written at the tail on
// enqueue and read at the head on dequeue. Each ring keeps one slot unused,
// so a queue holds at most RING_DEPTH-1 items. No clearing pass after reset.
module multi_queue_ring_buffer_unit #(
    parameter int NUM_QUEUES = mqrb_pkg::NUM_QUEUES_DEF,
    parameter int RING_DEPTH = mqrb_pkg::RING_DEPTH_DEF,
    parameter int ITEM_BITS  = mqrb_pkg::ITEM_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output      logic                              in_stall,
    input  wire logic                              req_type,
    input  wire logic [mqrb_pkg::QSEL_BITS-1:0]    queue_select,
    input  wire logic [mqrb_pkg::WORD_BITS-1:0]    item_word,
    output      logic                              out_valid,
    input  wire logic                              out_stall,
    output      logic [mqrb_pkg::STATUS_BITS-1:0]  op_status,
    output      logic [mqrb_pkg::WORD_BITS-1:0]    read_word,
    output      logic                              now_empty,
    output      logic                              now_full
);
    import mqrb_pkg::*;

    localparam int PTR_BITS  = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = NUM_QUEUES * RING_DEPTH;
    localparam int MEM_ABITS = $clog2(MEM_DEPTH);

    function automatic logic [PTR_BITS-1:0] ring_next(input logic [PTR_BITS-1:0] p);
        logic [PTR_BITS-1:0] n;
        n = (p == PTR_BITS'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
        return n;
    endfunction

    logic [PTR_BITS-1:0]  head_reg [NUM_QUEUES];
    logic [PTR_BITS-1:0]  head_next [NUM_QUEUES];
    logic [PTR_BITS-1:0]  tail_reg [NUM_QUEUES];
    logic [PTR_BITS-1:0]  tail_next [NUM_QUEUES];

    logic [ITEM_BITS-1:0] slot_mem [MEM_DEPTH];
    logic [ITEM_BITS-1:0] rd_data_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    status_t              s1_status_reg;
    logic                 s1_deq_ok_reg;
    logic                 s1_empty_reg;
    logic                 s1_full_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    status_t              out_status_reg;
    logic [WORD_BITS-1:0] out_word_reg;
    logic                 out_empty_reg;
    logic                 out_full_reg;

    logic                 accept;
    logic                 s1_move;
    logic                 q_valid;
    logic [PTR_BITS-1:0]  sel_head;
    logic [PTR_BITS-1:0]  sel_tail;
    logic                 is_empty;
    logic                 is_full;
    logic                 do_enq;
    logic                 do_deq;
    logic [PTR_BITS-1:0]  new_head;
    logic [PTR_BITS-1:0]  new_tail;
    logic                 post_empty;
    logic                 post_full;
    status_t              status;
    logic [MEM_ABITS-1:0] mem_addr;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        sel_head = '0;
        sel_tail = '0;
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            if (queue_select == QSEL_BITS'(q))
            begin
                sel_head = head_reg[q];
                sel_tail = tail_reg[q];
            end
        end
    end

    assign q_valid  = int'(queue_select) < NUM_QUEUES;
    assign is_empty = sel_head == sel_tail;
    assign is_full  = sel_head == ring_next(sel_tail);

    always_comb
    begin
        if (!q_valid)
            status = ST_INVALID;
        else if (req_type == REQ_ENQ)
            status = is_full ? ST_FULL : ST_DONE;
        else
            status = is_empty ? ST_EMPTY : ST_DONE;
    end

    assign do_enq     = accept && q_valid && (req_type == REQ_ENQ) && !is_full;
    assign do_deq     = accept && q_valid && (req_type == REQ_DEQ) && !is_empty;
    assign new_head   = do_deq ? ring_next(sel_head) : sel_head;
    assign new_tail   = do_enq ? ring_next(sel_tail) : sel_tail;
    assign post_empty = q_valid && (new_head == new_tail);
    assign post_full  = q_valid && (new_head == ring_next(new_tail));

    assign mem_addr = MEM_ABITS'(queue_select) * MEM_ABITS'(RING_DEPTH)
                    + MEM_ABITS'((req_type == REQ_ENQ) ? sel_tail : sel_head);

    always_comb
    begin
        for (int q = 0; q < NUM_QUEUES; q++)
        begin
            head_next[q] = head_reg[q];
            tail_next[q] = tail_reg[q];
            if (queue_select == QSEL_BITS'(q))
            begin
                head_next[q] = new_head;
                tail_next[q] = new_tail;
            end
        end
    end

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_move)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_QUEUES; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
            end
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_enq)
            slot_mem[mem_addr] <= item_word[ITEM_BITS-1:0];
        if (do_deq)
            rd_data_reg <= slot_mem[mem_addr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_status_reg <= status;
            s1_deq_ok_reg <= do_deq;
            s1_empty_reg  <= post_empty;
            s1_full_reg   <= post_full;
        end
        if (s1_move)
        begin
            out_status_reg <= s1_status_reg;
            out_word_reg   <= s1_deq_ok_reg ? WORD_BITS'(rd_data_reg) : '0;
            out_empty_reg  <= s1_empty_reg;
            out_full_reg   <= s1_full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign op_status = out_status_reg;
    assign read_word = out_word_reg;
    assign now_empty = out_empty_reg;
    assign now_full  = out_full_reg;

endmodule

`default_nettype wire

@@ src/mqrb_checker.sv @@
`default_nettype none

`include "assert_macros.svh"

module mqrb_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [mqrb_pkg::STATUS_BITS-1:0]  op_status,
    input wire logic [mqrb_pkg::WORD_BITS-1:0]    read_word,
    input wire logic                              now_empty,
    input wire logic                              now_full
);
    import mqrb_pkg::*;

    `ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(op_status) && $stable(read_word)
        && $stable(now_empty) && $stable(now_full), "stalled item changed")

    `ASSERT_IMP(a_word_zero, clk, rst_n, out_valid && (op_status != ST_DONE),
        read_word == '0, "read_word nonzero on failed request")

    `ASSERT_IMP(a_flags_excl, clk, rst_n, out_valid, !(now_empty && now_full),
        "queue reported both empty and full")

    `ASSERT_IMP(a_fail_flags, clk, rst_n, out_valid,
        ((op_status != ST_FULL) || (now_full && !now_empty))
        && ((op_status != ST_EMPTY) || (now_empty && !now_full))
        && ((op_status != ST_INVALID) || (!now_empty && !now_full)),
        "flags disagree with status")

endmodule

bind multi_queue_ring_buffer_unit mqrb_checker u_mqrb_checker (.*);

`default_nettype wire

@@ bench/multi_queue_ring_buffer_unit_tb.sv @@
module multi_queue_ring_buffer_unit_tb;

    import mqrb_pkg::*;

    localparam int QUEUE_COUNT = NUM_QUEUES_DEF;
    localparam int RING_SLOTS  = RING_DEPTH_DEF;
    localparam int ITEM_WIDTH  = ITEM_BITS_DEF;
    localparam logic [WORD_BITS-1:0] ITEM_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - ITEM_WIDTH);
    localparam logic [WORD_BITS-1:0] ALL_ONES  = {WORD_BITS{1'b1}};
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES  = 100;
    localparam int IDLE_LIMIT   = 3000;

    typedef struct {
        status_t              status;
        logic [WORD_BITS-1:0] word;
        logic                 empty;
        logic                 full;
    } queue_result_t;

    class ring_predictor;
        int unsigned          head_ptr[QUEUE_COUNT];
        int unsigned          tail_ptr[QUEUE_COUNT];
        logic [WORD_BITS-1:0] slot_mem[QUEUE_COUNT*RING_SLOTS];
        queue_result_t        awaited[$];
        int                   error_count;

        function new();
            foreach (head_ptr[i])
            begin
                head_ptr[i] = 0;
                tail_ptr[i] = 0;
            end
            error_count = 0;
        endfunction

        function int unsigned wrap_next(int unsigned p);
            return (p + 1 >= RING_SLOTS) ? 0 : p + 1;
        endfunction

        function bit is_empty(int unsigned q);
            return head_ptr[q] == tail_ptr[q];
        endfunction

        function bit is_full(int unsigned q);
            return head_ptr[q] == wrap_next(tail_ptr[q]);
        endfunction

        function void accept_request(logic op, logic [QSEL_BITS-1:0] q,
                                     logic [WORD_BITS-1:0] w);
            queue_result_t r;
            r.status = ST_DONE;
            r.word   = '0;
            r.empty  = 1'b0;
            r.full   = 1'b0;
            if (q >= QUEUE_COUNT)
            begin
                r.status = ST_INVALID;
            end
            else
            begin
                if (op == REQ_ENQ)
                begin
                    if (is_full(q))
                        r.status = ST_FULL;
                    else
                    begin
                        slot_mem[q*RING_SLOTS + tail_ptr[q]] = w & ITEM_MASK;
                        tail_ptr[q] = wrap_next(tail_ptr[q]);
                    end
                end
                else
                begin
                    if (is_empty(q))
                        r.status = ST_EMPTY;
                    else
                    begin
                        r.word = slot_mem[q*RING_SLOTS + head_ptr[q]] & ITEM_MASK;
                        head_ptr[q] = wrap_next(head_ptr[q]);
                    end
                end
                r.empty = is_empty(q);
                r.full  = is_full(q);
            end
            awaited.push_back(r);
        endfunction

        function void check_response(logic [STATUS_BITS-1:0] st, logic [WORD_BITS-1:0] word,
                                     logic emp, logic ful);
            queue_result_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result, status %0d word %h", $time, st, word);
                error_count++;
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: op_status expected %0d actual %0d", $time, want.status, st);
                error_count++;
            end
            if (word !== want.word)
            begin
                $display("%0t: read_word expected %h actual %h", $time, want.word, word);
                error_count++;
            end
            if (emp !== want.empty)
            begin
                $display("%0t: now_empty expected %b actual %b", $time, want.empty, emp);
                error_count++;
            end
            if (ful !== want.full)
            begin
                $display("%0t: now_full expected %b actual %b", $time, want.full, ful);
                error_count++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   req_type;
    logic [QSEL_BITS-1:0]   queue_select;
    logic [WORD_BITS-1:0]   item_word;
    logic                   out_valid;
    logic                   out_stall;
    logic [STATUS_BITS-1:0] op_status;
    logic [WORD_BITS-1:0]   read_word;
    logic                   now_empty;
    logic                   now_full;

    ring_predictor model = new();
    bit            hold_active = 1'b0;
    bit            send_quiet  = 1'b0;
    int            results_seen = 0;

    multi_queue_ring_buffer_unit #(
        .NUM_QUEUES (QUEUE_COUNT),
        .RING_DEPTH (RING_SLOTS),
        .ITEM_BITS  (ITEM_WIDTH)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .queue_select (queue_select),
        .item_word    (item_word),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .op_status    (op_status),
        .read_word    (read_word),
        .now_empty    (now_empty),
        .now_full     (now_full)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_request(input logic op, input logic [QSEL_BITS-1:0] q,
                                input logic [WORD_BITS-1:0] w);
        int gap;
        gap = (hold_active || send_quiet) ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= op;
        queue_select <= q;
        item_word    <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        model.accept_request(op, q, w);
    endtask

    function automatic logic [WORD_BITS-1:0] random_word();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return ALL_ONES;
        return {$urandom, $urandom};
    endfunction

    task automatic run_directed();
        for (int q = 0; q < QUEUE_COUNT; q++)
            send_request(REQ_DEQ, QSEL_BITS'(q), random_word());
        send_request(REQ_ENQ, 2'd3, ALL_ONES);
        send_request(REQ_DEQ, 2'd3, ALL_ONES);
        send_request(REQ_ENQ, 2'd0, '0);
        send_request(REQ_ENQ, 2'd0, ALL_ONES);
        for (int i = 2; i < RING_SLOTS - 1; i++)
            send_request(REQ_ENQ, 2'd0, random_word());
        // queue 0 is full now: this one is dropped
        send_request(REQ_ENQ, 2'd0, 64'h5A5A_5A5A_5A5A_5A5A);
        send_request(REQ_DEQ, 2'd0, ALL_ONES);
        send_request(REQ_DEQ, 2'd0, '0);
        send_request(REQ_ENQ, 2'd2, 64'h8000_0000_0000_0001);
        send_request(REQ_DEQ, 2'd2, '0);
    endtask

    task automatic run_random();
        int enq_pct;
        int focus;
        logic [QSEL_BITS-1:0] q;
        logic op;
        enq_pct = 50;
        focus   = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: enq_pct = 85;
                    1: enq_pct = 50;
                    default: enq_pct = 15;
                endcase
                focus = $urandom_range(0, QUEUE_COUNT - 1);
            end
            if (n % 20 == 0)
                send_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 8)
                q = 2'd3;
            else if ($urandom_range(0, 99) < 60)
                q = QSEL_BITS'(focus);
            else
                q = QSEL_BITS'($urandom_range(0, QUEUE_COUNT - 1));
            op = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
            send_request(op, q, random_word());
        end
    endtask

    // result side
    initial
    begin
        int gap;
        bit quiet;
        bit held;
        quiet = 1'b0;
        held  = 1'b0;
        out_stall = 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_seen % 20 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (!held && results_seen == 60)
            begin
                held = 1'b1;
                hold_active = 1'b1;
                gap = HOLD_CYCLES;
            end
            else
                gap = quiet ? 0 : $urandom_range(0, 18);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            hold_active = 1'b0;
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            model.check_response(op_status, read_word, now_empty, now_full);
            results_seen++;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        req_type     = REQ_ENQ;
        queue_select = '0;
        item_word    = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        in_valid <= 1'b0;
        while (model.awaited.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (model.error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
